/* src/mtdr_pkg.sv */
`timescale 1ns / 1ps

package mtdr_pkg;

  // ring geometry: two blocks of samples
  localparam int BLOCK      = 512;
  localparam int RING_DEPTH = 2 * BLOCK;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int WARM_W     = $clog2(BLOCK);

  // tap set and register map
  localparam int TAPS       = 4;
  localparam int TAP_W      = $clog2(TAPS);
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE  = CFG_IDX_W'(TAPS);
  localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = CFG_IDX_W'(2 * TAPS);

  // unsigned Q4.12 gains
  localparam int GAIN_ONE   = 4096;
  localparam int GAIN_RESET = 3277;
  localparam int GAIN_FRAC  = 12;

  // divider geometry: dividend is |num| + den/2, quotient never exceeds 32768
  localparam int DEN_W  = GAIN_W + 1;
  localparam int QUO_W  = 17;
  localparam int DVD_W  = 33;
  localparam int NUM_W  = 34;
  localparam int PROD_W = 33;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [DELAY_W-1:0]         delay_t;
  typedef logic [GAIN_W-1:0]          gain_t;

  // delays above one block read the sample just written
  function automatic addr_t tap_offset(input delay_t d);
    delay_t lim;
    lim = delay_t'(BLOCK);
    if (d > lim) begin
      return addr_t'(lim);
    end
    return addr_t'(d);
  endfunction

endpackage

/* src/mtdr_ram.sv */
`timescale 1ns / 1ps

module mtdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mtdr_div.sv */
`timescale 1ns / 1ps

module mtdr_div
  import mtdr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUO_W);

  // restoring divider, one quotient bit per cycle
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] dvd_r;
  logic [QUO_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, dvd_r[QUO_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[DVD_W-1:QUO_W]};
      dvd_r <= dividend[QUO_W-1:0];
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      dvd_r <= {dvd_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/multi_tap_delay_reverb.sv */
`timescale 1ns / 1ps

// multi-tap delay echo on a stream of signed Q1.15 samples. every transfer in
// yields exactly one transfer out: zero for the first 512 samples, then a
// sample lagging the input by 512 that is blended tap by tap with later ring
// entries, each tap forming (acc*4096 + x*g) / (4096 + g) rounded half away
// from zero. tap 0 always applies; taps 1..3 apply in order until the first
// zero delay; delays above 512 act as 512. one item is in flight at a time,
// and every applied tap waits on the bit-serial divider that yields one
// quotient bit per cycle. the ring lives in one 1024x16 ram with one
// write and one registered read port. it needs no clearing pass after
// reset: the warm-up period guarantees every entry is written before it
// is read. the output register lets the next sample transfer in while a
// result waits. configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while idle, the block does not enforce it.
// indexes 0..3 are the tap delays, 4..7 the Q4.12 gains, others are ignored.
module multi_tap_delay_reverb
  import mtdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // sample input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_sample_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_sample_out,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a sample
  localparam logic [2:0] S_BASE = 3'd1;  // base sample arrives from ram
  localparam logic [2:0] S_MUL  = 3'd2;  // tap sample arrives, multiply by gain
  localparam logic [2:0] S_SUM  = 3'd3;  // numerator add
  localparam logic [2:0] S_PREP = 3'd4;  // magnitude plus rounding, start divide
  localparam logic [2:0] S_DIV  = 3'd5;  // wait for quotient
  localparam logic [2:0] S_RD   = 3'd6;  // issue the next tap read
  localparam logic [2:0] S_OUT  = 3'd7;  // hand result to the output register

  logic [2:0]          state_r, state_nxt;
  addr_t               wp_r, rp_r;
  logic [WARM_W-1:0]   warm_cnt_r;
  logic                warmed_r;
  logic [TAP_W-1:0]    tap_r;
  sample_t             acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [NUM_W-1:0]  num_r;
  delay_t              delay_r [TAPS];
  gain_t               gain_r [TAPS];
  logic                out_valid_r;
  sample_t             out_sample_r;

  // ram side
  logic                ram_we;
  addr_t               ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  // divider side
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [DVD_W-1:0]    div_dividend;
  logic [DEN_W-1:0]    div_den;
  logic [QUO_W-1:0]    div_quo;

  logic                in_xfer;
  logic                out_load;
  logic                last_tap;
  logic [TAP_W-1:0]    tap_inc;
  logic [NUM_W-1:0]    dvd_full;
  logic signed [QUO_W:0] q_signed;
  sample_t             q_sat;
  logic [CFG_IDX_W-1:0] gain_idx;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // next tap applies only if it exists and its delay is nonzero
  assign tap_inc  = tap_r + TAP_W'(1);
  assign last_tap = (tap_r == TAP_W'(TAPS - 1)) || (delay_r[tap_inc] == '0);

  // ring write on every input transfer; read the base entry from idle,
  // otherwise the entry at the current tap's offset
  assign ram_we    = in_xfer;
  assign ram_raddr = (state_r == S_IDLE) ? rp_r : addr_t'(rp_r + tap_offset(delay_r[tap_r]));

  mtdr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_sample_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // divisor 4096 + g, dividend |num| + den/2
  assign div_den   = DEN_W'(GAIN_ONE) + {1'b0, gain_r[tap_r]};
  assign dvd_full  = num_r[NUM_W-1]
                   ? (NUM_W'(div_den[DEN_W-1:1]) - NUM_W'(num_r))
                   : (NUM_W'(num_r) + NUM_W'(div_den[DEN_W-1:1]));
  assign div_dividend = dvd_full[DVD_W-1:0];
  assign div_start    = (state_r == S_PREP);

  mtdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // restore the sign and clip to the sample range
  assign q_signed = num_r[NUM_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  always_comb begin
    if (q_signed > $signed((QUO_W+1)'(32767))) begin
      q_sat = 16'sh7fff;
    end else if (q_signed < -$signed((QUO_W+1)'(32768))) begin
      q_sat = 16'sh8000;
    end else begin
      q_sat = q_signed[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = warmed_r ? S_BASE : S_OUT;
        end
      end
      S_BASE: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = last_tap ? S_OUT : S_RD;
        end
      end
      S_RD:   state_nxt = S_MUL;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      warm_cnt_r  <= '0;
      warmed_r    <= 1'b0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        wp_r  <= wp_r + addr_t'(1);
        tap_r <= '0;
        if (!warmed_r) begin
          warm_cnt_r <= warm_cnt_r + WARM_W'(1);
          if (warm_cnt_r == WARM_W'(BLOCK - 1)) begin
            warmed_r <= 1'b1;
          end
        end
      end
      if (state_r == S_DIV && div_done) begin
        if (last_tap) begin
          rp_r <= rp_r + addr_t'(1);
        end else begin
          tap_r <= tap_inc;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_r <= '0;
    end else if (state_r == S_BASE) begin
      acc_r <= $signed(ram_rdata);
    end else if (state_r == S_DIV && div_done) begin
      acc_r <= q_sat;
    end
    if (state_r == S_MUL) begin
      prod_r <= $signed(ram_rdata) * $signed({1'b0, gain_r[tap_r]});
    end
    if (state_r == S_SUM) begin
      num_r <= $signed({{(NUM_W-SAMPLE_W-GAIN_FRAC){acc_r[SAMPLE_W-1]}}, acc_r, GAIN_FRAC'(0)})
             + $signed({prod_r[PROD_W-1], prod_r});
    end
    if (out_load) begin
      out_sample_r <= acc_r;
    end
  end

  // tap registers
  assign gain_idx = cfg_index - CFG_GAIN_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        delay_r[i] <= '0;
        gain_r[i]  <= gain_t'(GAIN_RESET);
      end
    end else if (cfg_we) begin
      if (cfg_index < CFG_GAIN_BASE) begin
        delay_r[cfg_index[TAP_W-1:0]] <= cfg_data[DELAY_W-1:0];
      end else if (cfg_index >= CFG_GAIN_BASE && cfg_index < CFG_REG_COUNT) begin
        gain_r[gain_idx[TAP_W-1:0]] <= cfg_data[GAIN_W-1:0];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

`ifndef ASSERT_OFF
  // read pointer trails the write pointer by one block once running
  a_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (warmed_r && state_r == S_IDLE) |-> (addr_t'(wp_r - rp_r) == addr_t'(BLOCK)))
    else $error("read pointer lag is not one block");

  // read pointer holds still during warm-up
  a_warm_rp: assert property (@(posedge clk) disable iff (!rst_n)
    !warmed_r |-> (rp_r == '0))
    else $error("read pointer moved during warm-up");

  // a new result only comes from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result loaded outside the output state");

  // divider is never restarted while busy
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule
